### sv/srld_pkg.sv
package srld_pkg;

    localparam int SPRITE_PIXELS_DEF = 1024;
    localparam int IDX_W             = 10;
    localparam int SIZE_W            = 16;
    localparam int CONS_W            = 18;

    typedef enum logic [2:0] {
        PH_KEY,
        PH_SIZE,
        PH_COUNT,
        PH_PIXEL,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        KIND_BACKGROUND,
        KIND_PIXEL,
        KIND_END
    } t_kind;

    // Configuration register indexes
    localparam logic REG_SOURCE_HAS_ALPHA = 1'b0;
    localparam logic REG_OUTPUT_ALPHA     = 1'b1;

    localparam logic [7:0] BYTE_FULL = 8'hFF;
    localparam logic [7:0] BYTE_ZERO = 8'h00;

    typedef struct packed {
        t_kind              kind;
        logic [IDX_W-1:0]   pixel_index;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         alpha;
        logic               last;
        logic               overrun;
    } t_result;

    typedef struct packed {
        logic source_has_alpha;
        logic output_alpha;
    } t_config;

endpackage

### sv/srld_in_if.sv
interface srld_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       record_start;
    logic       empty_record;

    modport source (output valid, output data_byte, output record_start,
                    output empty_record, input ready);
    modport sink   (input valid, input data_byte, input record_start,
                    input empty_record, output ready);
endinterface

### sv/srld_out_if.sv
interface srld_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [9:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last;
    logic       overrun;

    modport source (output valid, output kind, output pixel_index, output red,
                    output green, output blue, output alpha, output last,
                    output overrun, input ready);
    modport sink   (input valid, input kind, input pixel_index, input red,
                    input green, input blue, input alpha, input last,
                    input overrun, output ready);
endinterface

### sv/srld_parser.sv
module srld_parser #(
    parameter int SPRITE_PIXELS = srld_pkg::SPRITE_PIXELS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_data_byte,
    input  logic                i_record_start,
    input  logic                i_empty_record,
    input  srld_pkg::t_config   i_cfg,
    output logic                o_res_valid,
    output srld_pkg::t_result   o_res
);

    localparam int WPW   = $clog2(SPRITE_PIXELS + 1);
    localparam int SUM_W = ((WPW > srld_pkg::SIZE_W) ? WPW : srld_pkg::SIZE_W) + 1;
    localparam int EXT_W = (WPW > srld_pkg::IDX_W) ? WPW : srld_pkg::IDX_W;

    srld_pkg::t_phase              r_phase, n_phase;
    logic [1:0]                    r_bif, n_bif;
    logic [23:0]                   r_key, n_key;
    logic [srld_pkg::SIZE_W-1:0]   r_size, n_size;
    logic [srld_pkg::CONS_W-1:0]   r_cons, n_cons;
    logic [srld_pkg::SIZE_W-1:0]   r_run, n_run;
    logic                          r_crn, n_crn;
    logic [WPW-1:0]                r_wpos, n_wpos;
    logic [23:0]                   r_pp, n_pp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= srld_pkg::PH_KEY;
            r_bif   <= '0;
            r_key   <= '0;
            r_size  <= '0;
            r_cons  <= '0;
            r_run   <= '0;
            r_crn   <= 1'b0;
            r_wpos  <= '0;
            r_pp    <= '0;
        end else begin
            r_phase <= n_phase;
            r_bif   <= n_bif;
            r_key   <= n_key;
            r_size  <= n_size;
            r_cons  <= n_cons;
            r_run   <= n_run;
            r_crn   <= n_crn;
            r_wpos  <= n_wpos;
            r_pp    <= n_pp;
        end
    end

    logic [2:0]       w_bif_inc;
    logic [2:0]       w_need;
    logic [SUM_W-1:0] w_sum;
    logic [EXT_W-1:0] w_idx_ext;
    logic             w_ovr;
    logic             w_emit;

    always_comb begin
        n_phase   = r_phase;
        n_bif     = r_bif;
        n_key     = r_key;
        n_size    = r_size;
        n_cons    = r_cons;
        n_run     = r_run;
        n_crn     = r_crn;
        n_wpos    = r_wpos;
        n_pp      = r_pp;
        w_bif_inc = '0;
        w_need    = i_cfg.source_has_alpha ? 3'd4 : 3'd3;
        w_sum     = '0;
        w_idx_ext = '0;
        w_ovr     = 1'b0;
        w_emit    = 1'b0;
        o_res     = '0;

        if (i_accept) begin
            if (i_empty_record || i_record_start) begin
                n_phase = srld_pkg::PH_KEY;
                n_bif   = '0;
                n_key   = '0;
                n_size  = '0;
                n_cons  = '0;
                n_run   = '0;
                n_crn   = 1'b0;
                n_wpos  = '0;
                n_pp    = '0;
            end

            if (i_empty_record) begin
                n_phase = srld_pkg::PH_DONE;
                w_emit  = 1'b1;
                o_res.kind = srld_pkg::KIND_BACKGROUND;
                o_res.last = 1'b1;
                if (!i_cfg.output_alpha) begin
                    o_res.red  = srld_pkg::BYTE_FULL;
                    o_res.green = srld_pkg::BYTE_ZERO;
                    o_res.blue = srld_pkg::BYTE_FULL;
                end
            end else begin
                case (n_phase)
                    srld_pkg::PH_KEY: begin
                        n_key     = {n_key[15:0], i_data_byte};
                        w_bif_inc = {1'b0, n_bif} + 3'd1;
                        n_bif     = w_bif_inc[1:0];
                        if (w_bif_inc >= 3'd3) begin
                            n_bif   = '0;
                            n_phase = srld_pkg::PH_SIZE;
                            w_emit  = 1'b1;
                            o_res.kind = srld_pkg::KIND_BACKGROUND;
                            if (!i_cfg.output_alpha) begin
                                o_res.red   = n_key[23:16];
                                o_res.green = n_key[15:8];
                                o_res.blue  = n_key[7:0];
                            end
                        end
                    end
                    srld_pkg::PH_SIZE: begin
                        if (n_bif == 2'd0) begin
                            n_size = {8'd0, i_data_byte};
                            n_bif  = 2'd1;
                        end else begin
                            n_size = {i_data_byte, n_size[7:0]};
                            n_bif  = '0;
                            if (n_size == '0) begin
                                n_phase = srld_pkg::PH_DONE;
                                w_emit  = 1'b1;
                                o_res.kind = srld_pkg::KIND_END;
                                o_res.last = 1'b1;
                            end else begin
                                n_phase = srld_pkg::PH_COUNT;
                            end
                        end
                    end
                    srld_pkg::PH_COUNT: begin
                        if (n_cons != '1) begin
                            n_cons = n_cons + 1'b1;
                        end
                        if (n_bif == 2'd0) begin
                            n_run = {8'd0, i_data_byte};
                            n_bif = 2'd1;
                        end else begin
                            n_run = {i_data_byte, n_run[7:0]};
                            n_bif = '0;
                            if (n_crn && n_run != '0) begin
                                n_crn   = 1'b0;
                                n_phase = srld_pkg::PH_PIXEL;
                            end else begin
                                if (!n_crn) begin
                                    w_sum = SUM_W'(n_wpos) + SUM_W'(n_run);
                                    if (w_sum > SUM_W'(SPRITE_PIXELS)) begin
                                        n_wpos = WPW'(SPRITE_PIXELS);
                                    end else begin
                                        n_wpos = w_sum[WPW-1:0];
                                    end
                                end
                                n_run = '0;
                                n_crn = ~n_crn;
                                if (n_cons >= srld_pkg::CONS_W'(n_size)) begin
                                    n_phase = srld_pkg::PH_DONE;
                                    w_emit  = 1'b1;
                                    o_res.kind = srld_pkg::KIND_END;
                                    o_res.last = 1'b1;
                                end
                            end
                        end
                    end
                    srld_pkg::PH_PIXEL: begin
                        if (n_cons != '1) begin
                            n_cons = n_cons + 1'b1;
                        end
                        if (n_bif != 2'd3) begin
                            n_pp = {n_pp[15:0], i_data_byte};
                        end
                        w_bif_inc = {1'b0, n_bif} + 3'd1;
                        n_bif     = w_bif_inc[1:0];
                        if (w_bif_inc >= w_need) begin
                            n_bif     = '0;
                            w_ovr     = (n_wpos >= WPW'(SPRITE_PIXELS));
                            w_idx_ext = EXT_W'(n_wpos);
                            w_emit    = 1'b1;
                            o_res.kind        = srld_pkg::KIND_PIXEL;
                            o_res.pixel_index = w_ovr ? '0 : w_idx_ext[srld_pkg::IDX_W-1:0];
                            o_res.overrun     = w_ovr;
                            o_res.red         = n_pp[23:16];
                            o_res.green       = n_pp[15:8];
                            o_res.blue        = n_pp[7:0];
                            o_res.alpha       = i_cfg.source_has_alpha ? i_data_byte
                                                                       : srld_pkg::BYTE_FULL;
                            if (!w_ovr) begin
                                n_wpos = n_wpos + 1'b1;
                            end
                            if (n_run != '0) begin
                                n_run = n_run - 1'b1;
                            end
                            if (n_run == '0) begin
                                if (n_cons >= srld_pkg::CONS_W'(n_size)) begin
                                    n_phase    = srld_pkg::PH_DONE;
                                    o_res.last = 1'b1;
                                end else begin
                                    n_phase = srld_pkg::PH_COUNT;
                                end
                            end
                            n_pp = '0;
                        end
                    end
                    default: begin
                        // finished record: bytes are dropped until the next start
                    end
                endcase
            end
        end
        o_res_valid = w_emit;
    end

endmodule

### sv/srld_out_fifo.sv
module srld_out_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr_valid,
    input  srld_pkg::t_result   i_wr_data,
    output logic                o_wr_ready,
    output logic                o_rd_valid,
    output srld_pkg::t_result   o_rd_data,
    input  logic                i_rd_ready
);

    srld_pkg::t_result r_mem [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count;
    logic              w_push;
    logic              w_pop;

    assign o_wr_ready = (r_count != 2'd2);
    assign o_rd_valid = (r_count != 2'd0);
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign w_push     = i_wr_valid && o_wr_ready;
    assign w_pop      = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### sv/sprite_run_length_decoder_core.sv
// Channel   Dir  Transfer when          Payload
// i_data    in   valid && ready         data_byte, record_start, empty_record
// o_result  out  valid && ready         kind, pixel_index, red/green/blue/alpha,
//                                       last, overrun
// apb       in   psel&penable&pwrite    source_has_alpha (0x0), output_alpha (0x4)
//
// One byte per cycle while input ready is high; the parser update and the
// result are worked out in the cycle the byte is taken, and the result sits in
// a two-entry output queue from the next cycle on. Input ready drops only when
// both queue entries hold results that the sink has not taken.
// Reset (synchronous, active low) clears the parser, the queue and both
// registers; a record may start without record_start after reset.
module sprite_run_length_decoder_core #(
    parameter int SPRITE_PIXELS = srld_pkg::SPRITE_PIXELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    srld_in_if.sink     i_data,
    srld_out_if.source  o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    srld_pkg::t_config r_cfg;
    srld_pkg::t_result w_res;
    srld_pkg::t_result w_rd;
    logic              w_res_valid;
    logic              w_in_ready;
    logic              w_accept;
    logic              w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                srld_pkg::REG_SOURCE_HAS_ALPHA: r_cfg.source_has_alpha <= pwdata[0];
                srld_pkg::REG_OUTPUT_ALPHA:     r_cfg.output_alpha     <= pwdata[0];
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            srld_pkg::REG_SOURCE_HAS_ALPHA: prdata = {31'd0, r_cfg.source_has_alpha};
            srld_pkg::REG_OUTPUT_ALPHA:     prdata = {31'd0, r_cfg.output_alpha};
            default:                        prdata = '0;
        endcase
    end

    assign i_data.ready = w_in_ready;
    assign w_accept     = i_data.valid && w_in_ready;

    srld_parser #(
        .SPRITE_PIXELS (SPRITE_PIXELS)
    ) u_parser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_data_byte    (i_data.data_byte),
        .i_record_start (i_data.record_start),
        .i_empty_record (i_data.empty_record),
        .i_cfg          (r_cfg),
        .o_res_valid    (w_res_valid),
        .o_res          (w_res)
    );

    srld_out_fifo u_out_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_res_valid),
        .i_wr_data  (w_res),
        .o_wr_ready (w_in_ready),
        .o_rd_valid (o_result.valid),
        .o_rd_data  (w_rd),
        .i_rd_ready (o_result.ready)
    );

    assign o_result.kind        = w_rd.kind;
    assign o_result.pixel_index = w_rd.pixel_index;
    assign o_result.red         = w_rd.red;
    assign o_result.green       = w_rd.green;
    assign o_result.blue        = w_rd.blue;
    assign o_result.alpha       = w_rd.alpha;
    assign o_result.last        = w_rd.last;
    assign o_result.overrun     = w_rd.overrun;

    // a result produced by an accepted byte must land in the queue
    a_result_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_res_valid |=> o_result.valid)
        else $error("result of accepted byte not queued");

    a_empty_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_data.empty_record |-> w_res_valid && w_res.last)
        else $error("empty record did not close with a final result");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.kind == srld_pkg::KIND_END |-> o_result.last)
        else $error("end notice without last");

    a_overrun_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.overrun
            |-> o_result.kind == srld_pkg::KIND_PIXEL && o_result.pixel_index == '0)
        else $error("overrun on a non-pixel result or with an index");

endmodule

### tb/srld_check_pkg.sv
`timescale 1ns / 1ps

package srld_check_pkg;
    import srld_pkg::*;

    localparam int SPRITE_PIXELS = SPRITE_PIXELS_DEF;

    class sprite_pixel_checker;
        bit          has_alpha;
        bit          out_alpha;
        int          errors;
        int          parsed;

        t_phase      phase;
        int          field_pos;
        logic [23:0] key;
        logic [15:0] size;
        logic [17:0] consumed;
        logic [15:0] run_left;
        bit          colour_next;
        int          wpos;
        logic [23:0] partial;

        t_result     decoded_due[$];

        function new();
            has_alpha = 1'b0;
            out_alpha = 1'b0;
            errors    = 0;
            parsed    = 0;
            clear();
        endfunction

        function void clear();
            phase       = PH_KEY;
            field_pos   = 0;
            key         = '0;
            size        = '0;
            consumed    = '0;
            run_left    = '0;
            colour_next = 1'b0;
            wpos        = 0;
            partial     = '0;
        endfunction

        function int pending();
            return decoded_due.size();
        endfunction

        function void bump_consumed();
            if (consumed != 18'h3FFFF) begin
                consumed++;
            end
        endfunction

        // Works out what one accepted byte causes; returns 1 unless the byte is ignored.
        function bit note_byte(logic [7:0] b, logic st, logic em);
            t_result r;
            bit      emit;
            bit      ignored;
            int      need;
            r       = '0;
            emit    = 1'b0;
            ignored = (phase == PH_DONE) && !st && !em;
            if (em) begin
                clear();
                phase  = PH_DONE;
                r.kind = KIND_BACKGROUND;
                r.last = 1'b1;
                if (!out_alpha) begin
                    r.red   = BYTE_FULL;
                    r.green = BYTE_ZERO;
                    r.blue  = BYTE_FULL;
                end
                decoded_due.push_back(r);
                parsed++;
                return 1'b1;
            end
            if (st) begin
                clear();
            end
            case (phase)
                PH_KEY: begin
                    key = {key[15:0], b};
                    field_pos++;
                    if (field_pos >= 3) begin
                        field_pos = 0;
                        phase     = PH_SIZE;
                        r.kind    = KIND_BACKGROUND;
                        if (!out_alpha) begin
                            {r.red, r.green, r.blue} = key;
                        end
                        emit = 1'b1;
                    end
                end
                PH_SIZE: begin
                    if (field_pos == 0) begin
                        size      = {8'h00, b};
                        field_pos = 1;
                    end else begin
                        size[15:8] = b;
                        field_pos  = 0;
                        if (size == 0) begin
                            phase  = PH_DONE;
                            r.kind = KIND_END;
                            r.last = 1'b1;
                            emit   = 1'b1;
                        end else begin
                            phase = PH_COUNT;
                        end
                    end
                end
                PH_COUNT: begin
                    bump_consumed();
                    if (field_pos == 0) begin
                        run_left  = {8'h00, b};
                        field_pos = 1;
                    end else begin
                        run_left[15:8] = b;
                        field_pos      = 0;
                        if (colour_next && run_left != 0) begin
                            colour_next = 1'b0;
                            phase       = PH_PIXEL;
                        end else begin
                            // skip run, or a coloured run of zero which moves nothing
                            if (!colour_next) begin
                                wpos += run_left;
                                if (wpos > SPRITE_PIXELS) begin
                                    wpos = SPRITE_PIXELS;
                                end
                            end
                            run_left    = '0;
                            colour_next = !colour_next;
                            if (consumed >= size) begin
                                phase  = PH_DONE;
                                r.kind = KIND_END;
                                r.last = 1'b1;
                                emit   = 1'b1;
                            end
                        end
                    end
                end
                PH_PIXEL: begin
                    need = has_alpha ? 4 : 3;
                    bump_consumed();
                    if (field_pos < 3) begin
                        partial = {partial[15:0], b};
                    end
                    field_pos++;
                    if (field_pos >= need) begin
                        field_pos = 0;
                        r.kind    = KIND_PIXEL;
                        r.alpha   = has_alpha ? b : BYTE_FULL;
                        r.overrun = (wpos >= SPRITE_PIXELS);
                        r.pixel_index = r.overrun ? '0 : wpos[IDX_W-1:0];
                        if (wpos < SPRITE_PIXELS) begin
                            wpos++;
                        end
                        if (run_left > 0) begin
                            run_left--;
                        end
                        // a coloured run always completes, even past the payload size
                        if (run_left == 0) begin
                            if (consumed >= size) begin
                                phase  = PH_DONE;
                                r.last = 1'b1;
                            end else begin
                                phase = PH_COUNT;
                            end
                        end
                        {r.red, r.green, r.blue} = partial;
                        partial = '0;
                        emit    = 1'b1;
                    end
                end
                default: ;
            endcase
            if (emit) begin
                decoded_due.push_back(r);
            end
            if (!ignored) begin
                parsed++;
            end
            return !ignored;
        endfunction

        function void mismatch(string field, int unsigned want, int unsigned got);
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
            errors++;
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (decoded_due.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual kind %0d index %0d",
                         $time, got.kind, got.pixel_index);
                errors++;
                return;
            end
            want = decoded_due.pop_front();
            if (got.kind !== want.kind) mismatch("kind", want.kind, got.kind);
            if (got.pixel_index !== want.pixel_index)
                mismatch("pixel_index", want.pixel_index, got.pixel_index);
            if (got.red !== want.red) mismatch("red", want.red, got.red);
            if (got.green !== want.green) mismatch("green", want.green, got.green);
            if (got.blue !== want.blue) mismatch("blue", want.blue, got.blue);
            if (got.alpha !== want.alpha) mismatch("alpha", want.alpha, got.alpha);
            if (got.last !== want.last) mismatch("last", want.last, got.last);
            if (got.overrun !== want.overrun) mismatch("overrun", want.overrun, got.overrun);
        endfunction
    endclass

endpackage

### tb/sprite_run_length_decoder_core_tb.sv
`timescale 1ns / 1ps

module sprite_run_length_decoder_core_tb;
    import srld_pkg::*;
    import srld_check_pkg::*;

    localparam int ITEMS_PER_PHASE = 181;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_CYCLES     = 400;

    localparam int IDLE_NONE = 0;
    localparam int IDLE_SEND = 1;
    localparam int IDLE_RECV = 2;
    localparam int IDLE_BOTH = 3;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          idle_mode = IDLE_NONE;
    logic        hold_armed;
    bit          hold_done = 1'b0;
    int          hold_left = 0;
    int          cycles = 0;

    sprite_pixel_checker sb;

    srld_in_if  in_if();
    srld_out_if res_if();

    sprite_run_length_decoder_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_data   (in_if),
        .o_result (res_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, sb.pending());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off so the block backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            res_if.ready <= 1'b0;
        end else if (hold_armed && !hold_done) begin
            hold_left    <= HOLD_CYCLES;
            hold_done    <= 1'b1;
            res_if.ready <= 1'b0;
        end else if (idle_mode == IDLE_RECV) begin
            res_if.ready <= ($urandom_range(99) >= 67);
        end else if (idle_mode == IDLE_BOTH) begin
            res_if.ready <= ($urandom_range(99) >= 17);
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    // Transfer monitor on both channels
    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                void'(sb.note_byte(in_if.data_byte, in_if.record_start, in_if.empty_record));
            end
            if (res_if.valid && res_if.ready) begin
                got.kind        = t_kind'(res_if.kind);
                got.pixel_index = res_if.pixel_index;
                got.red         = res_if.red;
                got.green       = res_if.green;
                got.blue        = res_if.blue;
                got.alpha       = res_if.alpha;
                got.last        = res_if.last;
                got.overrun     = res_if.overrun;
                sb.check_result(got);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic st, input logic em);
        if (idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH) begin
            while ($urandom_range(99) < ((idle_mode == IDLE_SEND) ? 67 : 17)) begin
                in_if.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        in_if.valid        <= 1'b1;
        in_if.data_byte    <= b;
        in_if.record_start <= st;
        in_if.empty_record <= em;
        do begin
            @(posedge i_clk);
        end while (!in_if.ready);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[2] == REG_OUTPUT_ALPHA) begin
            sb.out_alpha = value[0];
        end else begin
            sb.has_alpha = value[0];
        end
    endtask

    // Drain every outstanding result, then give the block time to go quiet
    task automatic settle();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 6);
        repeat (n) begin
            send_byte(8'($urandom), ($urandom_range(9) == 0), ($urandom_range(9) == 0));
        end
    endtask

    task automatic send_record();
        logic [7:0]  body[$];
        logic [15:0] skip;
        logic [15:0] cols;
        logic [15:0] declared;
        int          pairs;
        int          bpp;
        bpp   = sb.has_alpha ? 4 : 3;
        pairs = $urandom_range(0, 4);
        for (int k = 0; k < pairs; k++) begin
            case ($urandom_range(9))
                0:       skip = 16'($urandom);
                1, 2:    skip = 16'($urandom_range(0, 1100));
                default: skip = 16'($urandom_range(0, 40));
            endcase
            body.push_back(skip[7:0]);
            body.push_back(skip[15:8]);
            // sometimes the payload closes on a skip run
            if (k == pairs - 1 && $urandom_range(3) == 0) break;
            cols = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 5));
            body.push_back(cols[7:0]);
            body.push_back(cols[15:8]);
            repeat (cols * bpp) body.push_back(8'($urandom));
        end
        case ($urandom_range(9))
            0:       declared = 16'($urandom_range(0, body.size() + 8));
            1:       declared = 16'($urandom);
            default: declared = 16'(body.size());
        endcase
        send_byte(8'($urandom), 1'b1, 1'b0);
        send_byte(8'($urandom), 1'b0, 1'b0);
        send_byte(8'($urandom), 1'b0, 1'b0);
        send_byte(declared[7:0], 1'b0, 1'b0);
        send_byte(declared[15:8], 1'b0, 1'b0);
        foreach (body[i]) begin
            send_byte(body[i], 1'b0, 1'b0);
        end
    endtask

    initial begin
        int goal;
        sb = new();
        goal = 0;
        i_rst_n            <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        hold_armed         <= 1'b0;
        in_if.valid        <= 1'b0;
        in_if.data_byte    <= '0;
        in_if.record_start <= 1'b0;
        in_if.empty_record <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_reg({REG_SOURCE_HAS_ALPHA, 2'b00}, 32'd0);
        write_reg({REG_OUTPUT_ALPHA, 2'b00}, 32'd0);

        // bytes straight after reset parse as a fresh record; zero payload size
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h80, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        // empty record wins over record_start, then a stray byte after the end
        send_byte(8'hFF, 1'b1, 1'b1);
        send_byte(8'h55, 1'b0, 1'b0);
        // skip to the last pixel, then a run that spills past the sprite
        send_byte(8'h01, 1'b1, 1'b0);
        send_byte(8'h02, 1'b0, 1'b0);
        send_byte(8'h03, 1'b0, 1'b0);
        send_byte(8'h0A, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h03, 1'b0, 1'b0);
        send_byte(8'h02, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        // empty record aborting one in progress
        send_byte(8'h7E, 1'b1, 1'b0);
        send_byte(8'h7F, 1'b0, 1'b1);

        for (int p = 0; p < 8; p++) begin
            settle();
            write_reg({REG_SOURCE_HAS_ALPHA, 2'b00}, 32'(p % 2));
            write_reg({REG_OUTPUT_ALPHA, 2'b00}, 32'((p / 2) % 2));
            idle_mode <= (p + p / 4) % 4;
            if (p == 0) begin
                hold_armed <= 1'b1;
            end
            goal = sb.parsed + ITEMS_PER_PHASE;
            while (sb.parsed < goal) begin
                if ($urandom_range(99) < 15) begin
                    send_noise();
                end else begin
                    send_record();
                end
            end
        end
        settle();
        repeat (4) @(posedge i_clk);

        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
